>>> rtl/double_ended_value_queue_top_macros.svh
// Assertion macros for the double-ended value queue.
// Included by the top level; no other dependencies.
`ifndef DOUBLE_ENDED_VALUE_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_VALUE_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DVQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DVQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DVQ_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DVQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/devq_pkg.sv
// Shared types and codes for the double-ended value queue.
// No dependencies; used by every module of the block.
package devq_pkg;

   localparam int VALUE_W = 64;
   localparam int COUNT_W = 9;

   localparam logic [1:0] ACT_PUSH_BACK  = 2'd0;
   localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
   localparam logic [1:0] ACT_POP_BACK   = 2'd2;
   localparam logic [1:0] ACT_POP_FRONT  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [VALUE_W-1:0]  value;
   } devq_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  popped_value;
      logic [1:0]                 status;
      logic [COUNT_W-1:0]         entry_count;
      logic                       is_empty;
   } devq_rsp_type;

   // Shift command broadcast to every cell; at most one bit is set.
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_back;
      logic pop_front;
   } devq_op_type;

   // What one cell shows its neighbors: occupancy, the front-ordered copy
   // and the back-ordered copy of its entry.
   typedef struct packed {
      logic                       valid;
      logic signed [VALUE_W-1:0]  f_data;
      logic signed [VALUE_W-1:0]  k_data;
   } devq_cell_type;

endpackage

>>> rtl/devq_cell.sv
// One storage cell of the queue chain: a valid bit and two 64-bit entries.
// Depends on devq_pkg.
module devq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  devq_pkg::devq_op_type  op,
   input  logic signed [63:0]     value,
   input  devq_pkg::devq_cell_type left_nb,
   input  devq_pkg::devq_cell_type right_nb,
   output devq_pkg::devq_cell_type state_out
);
   import devq_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] f_ff, f_in;
   logic signed [VALUE_W-1:0] k_ff, k_in;
   logic                      first_empty;

   // The cell just past the last held entry takes a value that is added
   // at the far end of a chain.
   assign first_empty = !valid_ff && left_nb.valid;

   always_comb begin
      valid_in = valid_ff;
      f_in     = f_ff;
      k_in     = k_ff;
      if (op.push_front) begin
         valid_in = left_nb.valid;
         f_in     = left_nb.f_data;
         if (first_empty) begin
            k_in = value;
         end
      end else if (op.push_back) begin
         valid_in = left_nb.valid;
         k_in     = left_nb.k_data;
         if (first_empty) begin
            f_in = value;
         end
      end else if (op.pop_front) begin
         valid_in = right_nb.valid;
         f_in     = right_nb.f_data;
      end else if (op.pop_back) begin
         valid_in = right_nb.valid;
         k_in     = right_nb.k_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      f_ff <= f_in;
      k_ff <= k_in;
   end

   assign state_out = '{valid: valid_ff, f_data: f_ff, k_data: k_ff};

endmodule

>>> rtl/devq_chain.sv
// Row of queue cells linked to their neighbors on both sides.
// Depends on devq_pkg and devq_cell.
module devq_chain #(
   parameter int DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  devq_pkg::devq_op_type   op,
   input  logic signed [63:0]      value,
   output devq_pkg::devq_cell_type head,
   output logic                    tail_valid
);
   import devq_pkg::*;

   devq_cell_type cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      devq_cell_type left_s;
      devq_cell_type right_s;

      if (i == 0) begin : g_first
         assign left_s = '{valid: 1'b1, f_data: value, k_data: value};
      end else begin : g_inner_l
         assign left_s = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_s = '{valid: 1'b0, f_data: '0, k_data: '0};
      end else begin : g_inner_r
         assign right_s = cell_q[i+1];
      end

      devq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .value     (value),
         .left_nb   (left_s),
         .right_nb  (right_s),
         .state_out (cell_q[i])
      );
   end

   assign head       = cell_q[0];
   assign tail_valid = cell_q[DEPTH-1].valid;

endmodule

>>> rtl/double_ended_value_queue_top.sv
// Top level of the double-ended value queue: handshakes, action decode,
// entry count and the registered result. Depends on devq_pkg, devq_chain
// and the assertion macro header.
//
//   channel | direction | ports                              | payload
//   --------+-----------+------------------------------------+---------------
//   req     | in        | req_valid, req_ready, req_payload  | devq_req_type
//   rsp     | out       | rsp_valid, rsp_ready, rsp_payload  | devq_rsp_type
//
// The cell chain shifts or fills in the cycle an item is accepted, and the
// result is registered for the next edge.
// Synchronous reset clears every cell's valid bit and the count at once,
// so the queue is empty and ready in the first cycle after reset.
// The result register lets a new item in whenever the held result is
// being taken in the same cycle; a stalled rsp side stalls req only then.
`include "double_ended_value_queue_top_macros.svh"

module double_ended_value_queue_top #(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  devq_pkg::devq_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output devq_pkg::devq_rsp_type rsp_payload
);
   import devq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // The queue is stored twice in the chain: in front order (front entry in
   // the first cell) and in back order (back entry in the first cell). Each
   // end is thus always at the first cell, and every action is a one-step
   // shift or a fill at the boundary between held and free cells.
   devq_cell_type head;
   logic          tail_valid;
   logic          req_fire;
   logic          is_full;
   logic          is_empty_now;
   logic          is_push;
   devq_op_type   op;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   devq_rsp_type  rsp_ff, rsp_in;
   logic [CW+COUNT_W-1:0] cnt_wide;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_fire     = req_valid && req_ready;
   assign is_full      = tail_valid;
   assign is_empty_now = !head.valid;

   // Decode the action; a push into a full queue or a pop from an empty
   // one leaves the chain alone.
   always_comb begin
      op = '0;
      if (req_fire) begin
         unique case (req_payload.action)
            ACT_PUSH_BACK:  op.push_back  = !is_full;
            ACT_PUSH_FRONT: op.push_front = !is_full;
            ACT_POP_BACK:   op.pop_back   = !is_empty_now;
            ACT_POP_FRONT:  op.pop_front  = !is_empty_now;
            default:        op = '0;
         endcase
      end
   end

   assign is_push = op.push_back || op.push_front;

   devq_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .value      (req_payload.value),
      .head       (head),
      .tail_valid (tail_valid)
   );

   always_comb begin
      cnt_in = cnt_ff;
      if (is_push) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (op.pop_back || op.pop_front) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // The reported count is the new count masked to the field width.
   assign cnt_wide = {{COUNT_W{1'b0}}, cnt_in};

   always_comb begin
      rsp_in.popped_value = '0;
      rsp_in.status       = ST_OK;
      unique case (req_payload.action) inside
         ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end
         end
         ACT_POP_BACK: begin
            if (is_empty_now) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.popped_value = head.k_data;
            end
         end
         ACT_POP_FRONT: begin
            if (is_empty_now) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.popped_value = head.f_data;
            end
         end
         default: rsp_in.status = ST_OK;
      endcase
      rsp_in.entry_count = cnt_wide[COUNT_W-1:0];
      rsp_in.is_empty    = (cnt_in == '0);
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The count and the chain's occupancy must agree at both ends.
   `DVQ_ASSERT_SAME(a_empty_agrees, clock, reset, 1'b1, (cnt_ff == '0) == !head.valid)
   `DVQ_ASSERT_SAME(a_full_agrees, clock, reset, tail_valid, cnt_ff == CW'(DEPTH))
   `DVQ_ASSERT_NEXT(a_push_grows, clock, reset, is_push, cnt_ff == $past(cnt_ff) + CW'(1))
   `DVQ_ASSERT_NEXT(a_result_follows, clock, reset, req_fire, rsp_valid_ff)

endmodule

>>> verif/double_ended_value_queue_top_tb.sv
`timescale 1ns / 1ps
// Testbench for double_ended_value_queue_top: an in-bench deque model scores every result.
// Depends on devq_pkg and the double_ended_value_queue_top RTL.
module double_ended_value_queue_top_tb;
   import devq_pkg::*;

   localparam int QUEUE_DEPTH   = 256;
   localparam int HALF_PERIOD   = 4;
   localparam int RANDOM_ITEMS  = 1250;   // mixed fill/drain traffic before the calm tail
   localparam int CALM_ITEMS    = 150;    // final stretch with no idling on either side
   localparam int HOLD_OFF      = 400;    // one long receiver stall to back up the input
   localparam int HOLD_AT       = 600;    // results checked before the long stall starts
   localparam int STALL_LIMIT   = 3000;   // cycles without any handshake before giving up
   localparam int SETTLE_CYCLES = 20;

   // The scoreboard models the queue as its own ring buffer. It is updated only
   // when an item is accepted, so its fill level is always current for the
   // stimulus generator as well.
   class deque_scoreboard;
      logic signed [VALUE_W-1:0] slots [QUEUE_DEPTH];
      int unsigned               head;
      int unsigned               held;
      devq_rsp_type              awaited [$];
      int                        errors;
      int                        n_items;
      int                        n_checked;
      int                        n_full;
      int                        n_empty;
      int unsigned               peak;

      function int unsigned level();
         return held;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(devq_req_type item);
         devq_rsp_type want;
         int unsigned  slot;
         want        = '0;
         want.status = ST_OK;
         n_items++;
         case (item.action)
            ACT_PUSH_BACK: begin
               if (held == QUEUE_DEPTH) begin
                  want.status = ST_FULL;
                  n_full++;
               end else begin
                  slot        = (head + held) % QUEUE_DEPTH;
                  slots[slot] = item.value;
                  held++;
               end
            end
            ACT_PUSH_FRONT: begin
               if (held == QUEUE_DEPTH) begin
                  want.status = ST_FULL;
                  n_full++;
               end else begin
                  head        = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                  slots[head] = item.value;
                  held++;
               end
            end
            ACT_POP_BACK: begin
               if (held == 0) begin
                  want.status = ST_EMPTY;
                  n_empty++;
               end else begin
                  slot              = (head + held - 1) % QUEUE_DEPTH;
                  want.popped_value = slots[slot];
                  held--;
               end
            end
            default: begin
               if (held == 0) begin
                  want.status = ST_EMPTY;
                  n_empty++;
               end else begin
                  want.popped_value = slots[head];
                  head              = (head + 1) % QUEUE_DEPTH;
                  held--;
               end
            end
         endcase
         want.entry_count = COUNT_W'(held);
         want.is_empty    = (held == 0);
         if (held > peak)
            peak = held;
         awaited.push_back(want);
      endfunction

      function void check_response(devq_rsp_type got);
         devq_rsp_type want;
         if (awaited.size() == 0) begin
            $error("result arrived with nothing outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         n_checked++;
         if (got.popped_value !== want.popped_value) begin
            $error("popped_value expected %0d actual %0d", want.popped_value, got.popped_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count expected %0d actual %0d", want.entry_count, got.entry_count);
            errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty expected %0d actual %0d", want.is_empty, got.is_empty);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   devq_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   devq_rsp_type rsp_payload;

   deque_scoreboard sb;
   bit              calm;          // set for the final stretch: no idling at all
   bit              gaps_allowed;  // toggles so that idle windows alternate with busy ones
   int              idle_cycles;

   double_ended_value_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // Idle windows come and go at random intervals, so that some long
   // stretches run back to back and others are broken up by gaps and stalls.
   initial begin
      gaps_allowed = 1'b1;
      forever begin
         repeat ($urandom_range(100, 300)) @(posedge clock);
         gaps_allowed = !gaps_allowed;
      end
   end

   // Picks a push value. Corner values turn up often enough to be pushed at
   // both ends and popped from both ends; the rest are full-width random.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 15))
         0:       v = {1'b0, {(VALUE_W-1){1'b1}}};
         1:       v = {1'b1, {(VALUE_W-1){1'b0}}};
         2:       v = '0;
         3:       v = '1;
         default: v = {$urandom(), $urandom()};
      endcase
      return v;
   endfunction

   // Offers one item and holds it until the block takes it. Valid stays high
   // into the next item unless a gap is drawn, so back-to-back items are
   // accepted on consecutive edges while req_ready stays high.
   task automatic drive_item(input logic [1:0] action, input logic signed [VALUE_W-1:0] value);
      devq_req_type item;
      item.action = action;
      item.value  = value;
      req_valid   = 1'b1;
      req_payload = item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      @(negedge clock);
      if (!calm && gaps_allowed && $urandom_range(0, 3) == 0) begin
         req_valid          = 1'b0;
         req_payload.action = 2'($urandom());
         req_payload.value  = {$urandom(), $urandom()};
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   // Sends one random item where push_pct is the chance of a push.
   // The end is random too; pops still carry random values, which the block
   // must ignore.
   task automatic drive_random(input int push_pct);
      logic [1:0] action;
      if ($urandom_range(0, 99) < push_pct)
         action = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      else
         action = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
      drive_item(action, pick_value());
   endtask

   // Receiver side. It stalls in random bursts while idling is allowed and,
   // once the run is well under way, holds off for a long stretch so that the
   // held result backs up and the block drops req_ready while items wait.
   initial begin
      bit held_off;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && !calm && sb.n_checked >= HOLD_AT) begin
            held_off  = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end else if (!calm && gaps_allowed && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Every result taken at a rising edge is scored against the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_payload);
   end

   // Watchdog: any cycle with a handshake on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sent;
      sb          = new();
      calm        = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Pops on an empty queue at both ends come first, then
      // the value extremes go in at both ends and come back out, a push at
      // the front wraps the front index below zero, and a single entry is
      // removed from the end opposite to the one it went in at.
      drive_item(ACT_POP_BACK,   pick_value());
      drive_item(ACT_POP_FRONT,  pick_value());
      drive_item(ACT_PUSH_FRONT, {1'b1, {(VALUE_W-1){1'b0}}});
      drive_item(ACT_PUSH_BACK,  {1'b0, {(VALUE_W-1){1'b1}}});
      drive_item(ACT_POP_BACK,   '0);
      drive_item(ACT_POP_FRONT,  '0);
      drive_item(ACT_POP_FRONT,  '1);
      drive_item(ACT_PUSH_BACK,  '1);
      drive_item(ACT_PUSH_FRONT, '0);
      drive_item(ACT_PUSH_BACK,  64'sh5555_5555_5555_5555);
      drive_item(ACT_PUSH_FRONT, 64'shAAAA_AAAA_AAAA_AAAA);
      drive_item(ACT_PUSH_BACK,  64'sd1);
      drive_item(ACT_POP_FRONT,  '1);
      drive_item(ACT_POP_BACK,   '1);
      drive_item(ACT_POP_FRONT,  '0);
      drive_item(ACT_POP_BACK,   '0);
      drive_item(ACT_POP_FRONT,  '0);
      drive_item(ACT_POP_BACK,   '0);
      drive_item(ACT_PUSH_FRONT, 64'sh0123_4567_89AB_CDEF);
      drive_item(ACT_POP_BACK,   '0);
      drive_item(ACT_PUSH_BACK,  64'shFEDC_BA98_7654_3210);
      drive_item(ACT_POP_FRONT,  '0);

      // Random part, in rounds: fill until full and push on past it, drain
      // until empty and pop on past that, then a balanced stretch that starts
      // near empty. The item budget can cut a round short.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         while (sent < RANDOM_ITEMS && sb.level() < QUEUE_DEPTH) begin
            drive_random(90);
            sent++;
         end
         for (int k = 0; k < 6 && sent < RANDOM_ITEMS; k++) begin
            drive_random(80);
            sent++;
         end
         while (sent < RANDOM_ITEMS && sb.level() > 0) begin
            drive_random(10);
            sent++;
         end
         for (int k = 0; k < 6 && sent < RANDOM_ITEMS; k++) begin
            drive_random(20);
            sent++;
         end
         for (int k = 0; k < 120 && sent < RANDOM_ITEMS; k++) begin
            drive_random(55);
            sent++;
         end
      end

      // Calm tail: both sides run flat out.
      calm = 1'b1;
      repeat (CALM_ITEMS) drive_random(50);
      req_valid = 1'b0;

      // Wait for the last results; the watchdog bounds this wait. A settling
      // wait then catches any stray result after the final one.
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d items and %0d checked results, peak fill %0d of %0d.",
               sb.n_items, sb.n_checked, sb.peak, QUEUE_DEPTH);
      $display("Refused pushes on a full queue: %0d, pops on an empty queue: %0d.",
               sb.n_full, sb.n_empty);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/devq_pkg.sv
rtl/devq_cell.sv
rtl/devq_chain.sv
rtl/double_ended_value_queue_top.sv
verif/double_ended_value_queue_top_tb.sv
